// ===== rtl/fmr_pkg.sv =====
// Shared types and constants for the framed message receiver.
`timescale 1ns / 1ps

package fmr_pkg;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [7:0] REBOOT_CHAR = 8'h72;  // 'r'
	localparam logic [7:0] REBOOT_FLAGS = 8'h01;
	localparam logic [7:0] REBOOT_LENGTH = 8'h01;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_BYTE = 3'd0,
		REG_TEXT_START = 3'd1,
		REG_TEXT_END   = 3'd2,
		REG_TIMEOUT    = 3'd3,
		REG_BUF_LIMIT  = 3'd4
	} cfg_reg_t;

	localparam logic [7:0] RST_START_BYTE = 8'd1;
	localparam logic [7:0] RST_TEXT_START = 8'd2;
	localparam logic [7:0] RST_TEXT_END = 8'd3;
	localparam logic [15:0] RST_TIMEOUT = 16'd100;
	localparam logic [6:0] RST_BUF_LIMIT = 7'd64;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_BYTE    = 3'd1,
		EV_CSUM    = 3'd2,
		EV_STX     = 3'd3,
		EV_ETX     = 3'd4,
		EV_OVER    = 3'd5,
		EV_TIMEOUT = 3'd6
	} event_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		event_t     event_res;
		logic [7:0] payload_byte;
		logic [5:0] payload_index;
		logic [7:0] frame_length;
		logic [7:0] frame_flags;
		logic       reboot_request;
		logic       last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic   load_len;
		logic   load_flags;
		logic   clr_count;
		logic   store_byte;
		logic   reload_timer;
		logic   stop_timer;
		logic   dec_timer;
		logic   rd_first;
		logic   rd_next;
		logic   out_load_err;
		logic   out_load_byte;
		event_t err_code;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_start;
		logic is_stx;
		logic is_etx;
		logic cs_ok;
		logic overflow;
		logic count_hit_len;
		logic count_zero;
		logic timer_run;
		logic timer_one;
		logic rd_last;
	} status_t;

endpackage

// ===== rtl/fmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/fmr_ctrl.sv =====
// Frame parsing and delivery sequencer.
`timescale 1ns / 1ps

module fmr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_kind,
	output logic             item_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  fmr_pkg::status_t sts,
	output fmr_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEN,
		S_FLAGS,
		S_STX,
		S_DATA,
		S_ETX,
		S_CS,
		S_LOAD,
		S_SEND
	} state_t;

	state_t state_q, state_d;
	logic   valid_q, valid_d;
	logic   busy, accept, taken;

	assign busy = (state_q == S_LOAD) || (state_q == S_SEND);
	assign item_stall = busy || (valid_q && result_stall);
	assign accept = item_valid && !item_stall;
	assign taken = valid_q && !result_stall;
	assign result_valid = valid_q;

	always_comb begin
		cmd = '0;
		cmd.err_code = fmr_pkg::EV_NONE;
		state_d = state_q;

		if (state_q == S_LOAD) begin
			cmd.out_load_byte = 1'b1;
			state_d = S_SEND;
		end else if (state_q == S_SEND) begin
			if (taken) begin
				if (sts.rd_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd_next = 1'b1;
					state_d = S_LOAD;
				end
			end
		end else if (accept && item_kind == fmr_pkg::KIND_TICK) begin
			if (sts.timer_run) begin
				cmd.dec_timer = 1'b1;
				if (sts.timer_one) begin
					cmd.out_load_err = 1'b1;
					cmd.err_code = fmr_pkg::EV_TIMEOUT;
					state_d = S_IDLE;
				end
			end
		end else if (accept) begin
			case (state_q)
				S_IDLE: begin
					if (sts.is_start) begin
						cmd.reload_timer = 1'b1;
						state_d = S_LEN;
					end
				end
				S_LEN: begin
					cmd.load_len = 1'b1;
					cmd.reload_timer = 1'b1;
					state_d = S_FLAGS;
				end
				S_FLAGS: begin
					cmd.load_flags = 1'b1;
					cmd.reload_timer = 1'b1;
					state_d = S_STX;
				end
				S_STX: begin
					if (!sts.is_stx) begin
						cmd.out_load_err = 1'b1;
						cmd.err_code = fmr_pkg::EV_STX;
						cmd.stop_timer = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.reload_timer = 1'b1;
						cmd.clr_count = 1'b1;
						state_d = S_DATA;
					end
				end
				S_DATA: begin
					if (sts.overflow) begin
						cmd.out_load_err = 1'b1;
						cmd.err_code = fmr_pkg::EV_OVER;
						cmd.stop_timer = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.store_byte = 1'b1;
						cmd.reload_timer = 1'b1;
						if (sts.count_hit_len) begin
							state_d = S_ETX;
						end
					end
				end
				S_ETX: begin
					if (!sts.is_etx) begin
						cmd.out_load_err = 1'b1;
						cmd.err_code = fmr_pkg::EV_ETX;
						cmd.stop_timer = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.reload_timer = 1'b1;
						state_d = S_CS;
					end
				end
				S_CS: begin
					cmd.stop_timer = 1'b1;
					if (!sts.cs_ok) begin
						cmd.out_load_err = 1'b1;
						cmd.err_code = fmr_pkg::EV_CSUM;
						state_d = S_IDLE;
					end else if (sts.count_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_first = 1'b1;
						state_d = S_LOAD;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end

		valid_d = valid_q;
		if (taken) begin
			valid_d = 1'b0;
		end
		if (cmd.out_load_err || cmd.out_load_byte) begin
			valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
		end
	end

endmodule

// ===== rtl/fmr_dp.sv =====
// Datapath: configuration, frame fields, timer, payload store and result register.
`timescale 1ns / 1ps

module fmr_dp #(
	parameter int PAYLOAD_DEPTH = 64,
	parameter int TIMER_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fmr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fmr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [7:0]                         rx_byte,
	input  fmr_pkg::cmd_t                      cmd,
	output fmr_pkg::status_t                   sts,
	output fmr_pkg::result_t                   result
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

	logic [7:0]             start_q, stx_q, etx_q;
	logic [15:0]            timeout_q;
	logic [6:0]             limit_q;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic [7:0]             len_q, flags_q, sum_q;
	logic [CW-1:0]          count_q, idx_q, count_inc, idx_inc;
	logic [6:0]             lim_eff;
	logic [AW-1:0]          raddr;
	logic [7:0]             rdata;
	fmr_pkg::result_t       result_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= fmr_pkg::RST_START_BYTE;
			stx_q <= fmr_pkg::RST_TEXT_START;
			etx_q <= fmr_pkg::RST_TEXT_END;
			timeout_q <= fmr_pkg::RST_TIMEOUT;
			limit_q <= fmr_pkg::RST_BUF_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				fmr_pkg::REG_START_BYTE: start_q <= cfg_data[7:0];
				fmr_pkg::REG_TEXT_START: stx_q <= cfg_data[7:0];
				fmr_pkg::REG_TEXT_END:   etx_q <= cfg_data[7:0];
				fmr_pkg::REG_TIMEOUT:    timeout_q <= cfg_data[15:0];
				fmr_pkg::REG_BUF_LIMIT:  limit_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign count_inc = count_q + CW'(1);
	assign idx_inc = idx_q + CW'(1);
	assign lim_eff = (limit_q > 7'(PAYLOAD_DEPTH)) ? 7'(PAYLOAD_DEPTH) : limit_q;

	// frame fields, timer, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			len_q <= '0;
			flags_q <= '0;
			sum_q <= '0;
			count_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.stop_timer) begin
				timer_q <= '0;
			end else if (cmd.reload_timer) begin
				timer_q <= TIMER_WIDTH'(timeout_q);
			end else if (cmd.dec_timer) begin
				timer_q <= timer_q - TIMER_WIDTH'(1);
			end
			if (cmd.load_len) begin
				len_q <= rx_byte;
				sum_q <= rx_byte;
			end
			if (cmd.load_flags) begin
				flags_q <= rx_byte;
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.clr_count) begin
				count_q <= '0;
			end
			if (cmd.store_byte) begin
				sum_q <= sum_q + rx_byte;
				count_q <= count_inc;
			end
			if (cmd.rd_first) begin
				idx_q <= '0;
			end else if (cmd.rd_next) begin
				idx_q <= idx_inc;
			end
		end
	end

	assign raddr = cmd.rd_first ? '0 : idx_inc[AW-1:0];

	fmr_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.store_byte),
		.waddr(count_q[AW-1:0]),
		.wdata(rx_byte),
		.re   (cmd.rd_first || cmd.rd_next),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts.is_start = (rx_byte == start_q);
		sts.is_stx = (rx_byte == stx_q);
		sts.is_etx = (rx_byte == etx_q);
		sts.cs_ok = (rx_byte == 8'(8'd0 - sum_q));
		sts.overflow = (7'(count_q) >= lim_eff);
		sts.count_hit_len = (8'(count_inc) == len_q);
		sts.count_zero = (count_q == '0);
		sts.timer_run = (timer_q != '0);
		sts.timer_one = (timer_q == TIMER_WIDTH'(1));
		sts.rd_last = (idx_inc == count_q);
	end

	// result register; a reboot request needs length one, so the only byte read is entry zero
	always_ff @(posedge clk) begin
		if (cmd.out_load_err) begin
			result_q.event_res <= cmd.err_code;
			result_q.payload_byte <= '0;
			result_q.payload_index <= '0;
			result_q.frame_length <= '0;
			result_q.frame_flags <= '0;
			result_q.reboot_request <= 1'b0;
			result_q.last <= 1'b1;
		end else if (cmd.out_load_byte) begin
			result_q.event_res <= fmr_pkg::EV_BYTE;
			result_q.payload_byte <= rdata;
			result_q.payload_index <= 6'(idx_q);
			result_q.frame_length <= len_q;
			result_q.frame_flags <= flags_q;
			result_q.reboot_request <= (flags_q == fmr_pkg::REBOOT_FLAGS) &&
				(len_q == fmr_pkg::REBOOT_LENGTH) && (rdata == fmr_pkg::REBOOT_CHAR);
			result_q.last <= sts.rd_last;
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/framed_message_receiver.sv =====
// Top level of the framed message receiver.
`timescale 1ns / 1ps

// Each input beat is a received byte or a timer tick, taken unless stalled; frames
// are start byte, length, flags, text start, payload, text end, checksum, where the
// checksum is the two's complement of the 8-bit sum of length, flags and payload. An
// error (text start, text end, overflow, checksum, timeout) gives one result beat with
// last set. A good frame of n payload bytes gives n result beats, each byte read from
// the payload RAM (registered read) into the output register; input is stalled during
// that delivery. The payload RAM needs no clearing after reset.
module framed_message_receiver #(
	parameter int PAYLOAD_DEPTH = 64,
	parameter int TIMER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  fmr_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output fmr_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [fmr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fmr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	fmr_pkg::cmd_t    cmd;
	fmr_pkg::status_t sts;

	fmr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_kind   (item.kind),
		.item_stall  (item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	fmr_dp #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH),
		.TIMER_WIDTH  (TIMER_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rx_byte  (item.rx_byte),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

endmodule

// ===== dv/framed_message_receiver_tb.sv =====
// Self-checking testbench for the framed message receiver: directed frames, then random traffic.
`timescale 1ns / 1ps

module framed_message_receiver_tb;

	localparam int BUF_DEPTH = 64;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_BEATS = 57;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int N_DIRECTED = 27;

	typedef enum logic [2:0] {
		RX_IDLE, RX_LEN, RX_FLAGS, RX_STX, RX_DATA, RX_ETX, RX_CSUM
	} rx_phase_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       rx;
		logic             typed;
		fmr_pkg::event_t  want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	fmr_pkg::item_t item;
	logic result_valid;
	logic result_stall;
	fmr_pkg::result_t result;
	logic cfg_we;
	logic [fmr_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [fmr_pkg::CFG_DATA_W-1:0] cfg_data;

	// receiver mirror: configuration and frame state
	logic [7:0] start_code, stx_code, etx_code;
	logic [15:0] reload_ticks;
	logic [6:0] size_limit;
	rx_phase_t rx_phase;
	logic [15:0] ticks_left;
	logic [7:0] hdr_len, hdr_flags, csum_acc;
	logic [6:0] data_count;
	logic [7:0] data_buf [0:BUF_DEPTH-1];

	fmr_pkg::result_t awaited_events [$];
	stim_row_t directed_rows [0:N_DIRECTED-1];
	int fail_count = 0;
	int beats_sent = 0;
	logic no_idle = 1'b0;

	framed_message_receiver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic fmr_pkg::result_t error_result(fmr_pkg::event_t ev);
		fmr_pkg::result_t r;
		r = '0;
		r.event_res = ev;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void post_error(fmr_pkg::event_t ev);
		rx_phase = RX_IDLE;
		ticks_left = '0;
		awaited_events.push_back(error_result(ev));
	endfunction

	// advance the mirror by one beat, queueing the events it causes
	function automatic void decode_beat(fmr_pkg::item_t it);
		int lim;
		int n;
		logic rb;
		logic [7:0] b;
		fmr_pkg::result_t r;
		b = it.rx_byte;
		if (it.kind == fmr_pkg::KIND_TICK) begin
			if (ticks_left != '0) begin
				ticks_left = ticks_left - 16'd1;
				if (ticks_left == '0)
					post_error(fmr_pkg::EV_TIMEOUT);
			end
			return;
		end
		case (rx_phase)
			RX_IDLE: begin
				if (b == start_code) begin
					ticks_left = reload_ticks;
					rx_phase = RX_LEN;
				end
			end
			RX_LEN: begin
				hdr_len = b;
				csum_acc = b;
				ticks_left = reload_ticks;
				rx_phase = RX_FLAGS;
			end
			RX_FLAGS: begin
				hdr_flags = b;
				csum_acc = csum_acc + b;
				ticks_left = reload_ticks;
				rx_phase = RX_STX;
			end
			RX_STX: begin
				if (b != stx_code) begin
					post_error(fmr_pkg::EV_STX);
				end else begin
					ticks_left = reload_ticks;
					data_count = '0;
					rx_phase = RX_DATA;
				end
			end
			RX_DATA: begin
				lim = (size_limit > BUF_DEPTH) ? BUF_DEPTH : int'(size_limit);
				if (int'(data_count) >= lim) begin
					post_error(fmr_pkg::EV_OVER);
				end else begin
					data_buf[data_count[5:0]] = b;
					csum_acc = csum_acc + b;
					ticks_left = reload_ticks;
					data_count = data_count + 7'd1;
					if ({1'b0, data_count} == hdr_len)
						rx_phase = RX_ETX;
				end
			end
			RX_ETX: begin
				if (b != etx_code) begin
					post_error(fmr_pkg::EV_ETX);
				end else begin
					ticks_left = reload_ticks;
					rx_phase = RX_CSUM;
				end
			end
			default: begin
				if (b != 8'(8'd0 - csum_acc)) begin
					post_error(fmr_pkg::EV_CSUM);
				end else begin
					rx_phase = RX_IDLE;
					ticks_left = '0;
					n = int'(data_count);
					rb = (hdr_flags == fmr_pkg::REBOOT_FLAGS &&
						hdr_len == fmr_pkg::REBOOT_LENGTH &&
						data_buf[0] == fmr_pkg::REBOOT_CHAR);
					for (int i = 0; i < n; i++) begin
						r.event_res = fmr_pkg::EV_BYTE;
						r.payload_byte = data_buf[i];
						r.payload_index = 6'(i);
						r.frame_length = hdr_len;
						r.frame_flags = hdr_flags;
						r.reboot_request = rb;
						r.last = (i + 1 == n);
						awaited_events.push_back(r);
					end
				end
			end
		endcase
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_beat(logic kind, logic [7:0] b, logic typed, fmr_pkg::event_t want);
		int gap;
		int n0;
		fmr_pkg::item_t beat;
		beat.kind = kind;
		beat.rx_byte = b;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		beats_sent++;
		n0 = awaited_events.size();
		decode_beat(beat);
		// typed rows replace whatever the mirror queued with the hand-written event
		if (typed) begin
			while (awaited_events.size() > n0)
				void'(awaited_events.pop_back());
			if (want != fmr_pkg::EV_NONE)
				awaited_events.push_back(error_result(want));
		end
	endtask

	task automatic send_byte(logic [7:0] b);
		send_beat(fmr_pkg::KIND_BYTE, b, 1'b0, fmr_pkg::EV_NONE);
	endtask

	task automatic maybe_ticks();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (r < 8)
			n = $urandom_range(1, 2);
		else if (r < 11 && reload_ticks <= 16'd20)
			n = int'(reload_ticks);
		repeat (n) send_beat(fmr_pkg::KIND_TICK, 8'($urandom), 1'b0, fmr_pkg::EV_NONE);
	endtask

	task automatic send_frame();
		int lim, pick, len, pay_n, small_top, full_top;
		logic [7:0] flg, b, s;
		lim = (size_limit > BUF_DEPTH) ? BUF_DEPTH : int'(size_limit);
		full_top = (lim < 1) ? 1 : lim;
		small_top = (full_top < 8) ? full_top : 8;
		pick = $urandom_range(0, 99);
		flg = 8'($urandom);
		if (pick < 6) begin
			len = 1;
			if ($urandom_range(0, 3) != 0)
				flg = fmr_pkg::REBOOT_FLAGS;
		end else if (pick < 80) begin
			len = $urandom_range(1, small_top);
		end else if (pick < 88) begin
			len = $urandom_range(1, full_top);
		end else if (pick < 91) begin
			len = full_top;
		end else if (pick < 95) begin
			len = 0;
		end else begin
			len = $urandom_range(lim + 1, 255);
		end
		// zero or oversized length: send just enough bytes to overflow
		pay_n = (len == 0 || len > lim) ? lim + 1 : len;
		maybe_ticks();
		send_byte(start_code);
		maybe_ticks();
		send_byte(8'(len));
		maybe_ticks();
		send_byte(flg);
		s = 8'(len) + flg;
		maybe_ticks();
		if ($urandom_range(0, 19) == 0)
			send_byte(stx_code ^ 8'($urandom_range(1, 255)));
		else
			send_byte(stx_code);
		for (int i = 0; i < pay_n; i++) begin
			b = (pick < 6 && $urandom_range(0, 3) != 0) ? fmr_pkg::REBOOT_CHAR : 8'($urandom);
			s = s + b;
			maybe_ticks();
			send_byte(b);
		end
		maybe_ticks();
		if ($urandom_range(0, 19) == 0)
			send_byte(etx_code ^ 8'($urandom_range(1, 255)));
		else
			send_byte(etx_code);
		maybe_ticks();
		if ($urandom_range(0, 11) == 0)
			send_byte(8'(8'd0 - s) ^ 8'($urandom_range(1, 255)));
		else
			send_byte(8'(8'd0 - s));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(0, 2) == 0)
				send_beat(fmr_pkg::KIND_TICK, 8'($urandom), 1'b0, fmr_pkg::EV_NONE);
			else if ($urandom_range(0, 3) == 0)
				send_byte(start_code);
			else
				send_byte(8'($urandom));
		end
	endtask

	// push the receiver back to idle with bytes that end the frame
	task automatic drain_frame();
		logic [7:0] b;
		while (rx_phase != RX_IDLE) begin
			case (rx_phase)
				RX_STX: b = stx_code ^ 8'h01;
				RX_ETX: b = etx_code ^ 8'h01;
				RX_CSUM: b = 8'(8'd0 - csum_acc) ^ 8'h01;
				default: b = 8'($urandom);
			endcase
			send_byte(b);
		end
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(fmr_pkg::cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic program_regs(logic [7:0] sb, logic [7:0] tsb, logic [7:0] teb,
			logic [15:0] tmo, logic [6:0] lim);
		write_reg(fmr_pkg::REG_START_BYTE, 16'(sb));
		write_reg(fmr_pkg::REG_TEXT_START, 16'(tsb));
		write_reg(fmr_pkg::REG_TEXT_END, 16'(teb));
		write_reg(fmr_pkg::REG_TIMEOUT, tmo);
		write_reg(fmr_pkg::REG_BUF_LIMIT, 16'(lim));
		@(negedge clk);
		cfg_we <= 1'b0;
		start_code = sb;
		stx_code = tsb;
		etx_code = teb;
		reload_ticks = tmo;
		size_limit = lim;
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		fmr_pkg::result_t want;
		if (result_valid && !result_stall) begin
			if (awaited_events.size() == 0) begin
				$error("result beat with nothing awaited: event_res %0d", result.event_res);
				fail_count++;
			end else begin
				want = awaited_events.pop_front();
				check_field("event_res", 8'(want.event_res), 8'(result.event_res));
				check_field("payload_byte", want.payload_byte, result.payload_byte);
				check_field("payload_index", 8'(want.payload_index),
					8'(result.payload_index));
				check_field("frame_length", want.frame_length, result.frame_length);
				check_field("frame_flags", want.frame_flags, result.frame_flags);
				check_field("reboot_request", 8'(want.reboot_request),
					8'(result.reboot_request));
				check_field("last", 8'(want.last), 8'(result.last));
			end
		end
	end

	initial begin : sink_stall
		int hold;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	initial begin : watchdog
		#15_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start_code = fmr_pkg::RST_START_BYTE;
		stx_code = fmr_pkg::RST_TEXT_START;
		etx_code = fmr_pkg::RST_TEXT_END;
		reload_ticks = fmr_pkg::RST_TIMEOUT;
		size_limit = fmr_pkg::RST_BUF_LIMIT;
		rx_phase = RX_IDLE;
		ticks_left = '0;
		hdr_len = '0;
		hdr_flags = '0;
		csum_acc = '0;
		data_count = '0;

		directed_rows = '{
			// tick with timer stopped, then a stray byte in idle
			'{fmr_pkg::KIND_TICK, 8'h00, 1'b1, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h55, 1'b1, fmr_pkg::EV_NONE},
			// good frame, flags and payload at the extremes, checksum zero
			'{fmr_pkg::KIND_BYTE, 8'h01, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h02, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'hFF, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h02, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h00, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'hFF, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h03, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h00, 1'b0, fmr_pkg::EV_NONE},
			// reboot request frame
			'{fmr_pkg::KIND_BYTE, 8'h01, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h01, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h01, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h02, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h72, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h03, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h8C, 1'b0, fmr_pkg::EV_NONE},
			// wrong text start
			'{fmr_pkg::KIND_BYTE, 8'h01, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h80, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h00, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h00, 1'b1, fmr_pkg::EV_STX},
			// wrong text end
			'{fmr_pkg::KIND_BYTE, 8'h01, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h01, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h00, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h02, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'h11, 1'b0, fmr_pkg::EV_NONE},
			'{fmr_pkg::KIND_BYTE, 8'hFF, 1'b1, fmr_pkg::EV_ETX}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_beat(directed_rows[i].kind, directed_rows[i].rx, directed_rows[i].typed,
				directed_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_frame();
			wait_quiet();
			case (p)
				0: program_regs(8'h00, 8'hFF, 8'h00, 16'd1, 7'd1);
				1: program_regs(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 7'd64);
				// timer off, limit above the store depth
				2: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'd0, 7'd127);
				// zero limit: the first payload byte of every frame overflows
				3: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'd4, 7'd0);
				default: program_regs(8'($urandom), 8'($urandom), 8'($urandom),
					16'($urandom_range(2, 16)),
					7'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 64)));
			endcase
			no_idle = (p % 3 == 2);
			while (beats_sent < N_DIRECTED + (p + 1) * PHASE_BEATS) begin
				if (rx_phase != RX_IDLE && $urandom_range(0, 3) != 0)
					drain_frame();
				if ($urandom_range(0, 3) != 0)
					send_frame();
				else
					send_noise();
			end
		end

		no_idle = 1'b0;
		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited_events.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fmr_pkg.sv
rtl/fmr_ram.sv
rtl/fmr_ctrl.sv
rtl/fmr_dp.sv
rtl/framed_message_receiver.sv
dv/framed_message_receiver_tb.sv
